### rtl/frbc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// frbc_pkg
// Shared types, tables and the single Feistel round for the block cipher.
// ============================================================================
package frbc_pkg;

  localparam int BLOCK_W      = 64;
  localparam int HALF_W       = 32;
  localparam int KEY_W        = 48;
  localparam int BUF_W        = 56;
  localparam int QUEUE_DEPTH  = 2;

  // Block made of eight pad bytes of value 8
  localparam logic [BLOCK_W-1:0] PAD_BLOCK = 64'h0808_0808_0808_0808;

  // Expansion table, MSB-first bit numbering
  localparam logic [4:0] EXP_TAB [48] = '{
    5'd31, 5'd0,  5'd1,  5'd2,  5'd3,  5'd4,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,
    5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16,
    5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24,
    5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd0
  };

  // One four-row table shared by all eight S-boxes
  localparam logic [3:0] SBOX_TAB [4][16] = '{
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
    '{4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6},
    '{4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14},
    '{4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3}
  };

  // Output permutation, MSB-first bit numbering
  localparam logic [4:0] PERM_TAB [32] = '{
    5'd15, 5'd6,  5'd19, 5'd20, 5'd28, 5'd11, 5'd27, 5'd16,
    5'd0,  5'd14, 5'd22, 5'd25, 5'd4,  5'd17, 5'd30, 5'd9,
    5'd1,  5'd7,  5'd23, 5'd13, 5'd31, 5'd26, 5'd2,  5'd8,
    5'd18, 5'd12, 5'd29, 5'd5,  5'd21, 5'd10, 5'd3,  5'd24
  };

  // Block job handed from the packer to the round stage
  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    logic               last;       // final block of the message
    logic               pad_extra;  // a full pad block follows this one
  } frbc_job_t;

  // One Feistel round: output is R followed by L ^ f(R, key)
  function automatic logic [BLOCK_W-1:0] frbc_round(input logic [BLOCK_W-1:0] blk,
                                                    input logic [KEY_W-1:0]   key);
    logic [HALF_W-1:0] l;
    logic [HALF_W-1:0] r;
    logic [KEY_W-1:0]  e;
    logic [HALF_W-1:0] s;
    logic [HALF_W-1:0] p;
    logic [5:0]        g;
    l = blk[BLOCK_W-1:HALF_W];
    r = blk[HALF_W-1:0];
    for (int i = 0; i < KEY_W; i++) begin
      e[KEY_W-1-i] = r[HALF_W-1-int'(EXP_TAB[i])];
    end
    e = e ^ key;
    for (int i = 0; i < 8; i++) begin
      g = e[KEY_W-6-6*i +: 6];
      s[HALF_W-4-4*i +: 4] = SBOX_TAB[{g[5], g[0]}][g[4:1]];
    end
    for (int i = 0; i < HALF_W; i++) begin
      p[HALF_W-1-i] = s[HALF_W-1-int'(PERM_TAB[i])];
    end
    return {r, l ^ p};
  endfunction

endpackage

### rtl/frbc_if.sv
`timescale 1ns / 1ps
// ============================================================================
// frbc channel interfaces
// Byte input channel and cipher block output channel, valid/ready.
// ============================================================================
interface frbc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface frbc_block_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_block;
  logic        last_block;

  modport source (output valid, output cipher_block, output last_block, input ready);
  modport sink   (input valid, input cipher_block, input last_block, output ready);
endinterface

### rtl/frbc_front.sv
`timescale 1ns / 1ps
// ============================================================================
// frbc_front
// Packs bytes into blocks, applies padding and classifies each block job.
// ============================================================================
module frbc_front (
  input  logic                clk,
  input  logic                rst_n,
  frbc_byte_if.sink           in_bus,
  input  logic                q_full,
  output logic                push,
  output frbc_pkg::frbc_job_t push_job
);
  import frbc_pkg::*;

  logic [BUF_W-1:0]   buffer_r;
  logic [2:0]         count_r;
  logic               accept;
  logic [BLOCK_W-1:0] acc;
  logic [BLOCK_W-1:0] padded;
  logic [2:0]         pad;
  logic               full_blk;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && !q_full;
  assign acc          = {buffer_r, in_bus.data_byte};
  assign full_blk     = (count_r == 3'd7);
  assign pad          = 3'd7 - count_r;

  // Partial block: shift the held bytes up, fill the low bytes with the pad value
  always_comb begin
    padded = acc << {pad, 3'b000};
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < pad) begin
        padded[8*i +: 8] = {5'd0, pad};
      end
    end
  end

  always_comb begin
    push               = accept && (full_blk || in_bus.end_of_message);
    push_job.block     = full_blk ? acc : padded;
    push_job.last      = !full_blk;
    push_job.pad_extra = full_blk && in_bus.end_of_message;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 3'd0;
    end else if (accept) begin
      if (full_blk || in_bus.end_of_message) begin
        count_r <= 3'd0;
      end else begin
        count_r <= count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buffer_r <= acc[BUF_W-1:0];
    end
  end

endmodule

### rtl/frbc_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// frbc_queue
// Short job queue between the packer and the round stage.
// ============================================================================
module frbc_queue #(
  parameter int DEPTH = frbc_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  frbc_pkg::frbc_job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output frbc_pkg::frbc_job_t head_job
);
  import frbc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frbc_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/frbc_back.sv
`timescale 1ns / 1ps
// ============================================================================
// frbc_back
// Holds the round key, runs the Feistel round and drives the output register.
// ============================================================================
module frbc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [frbc_pkg::KEY_W-1:0]   cfg_wdata,
  input  logic                         head_valid,
  input  frbc_pkg::frbc_job_t          head_job,
  output logic                         pop,
  frbc_block_if.source                 out_bus
);
  import frbc_pkg::*;

  logic [KEY_W-1:0]   key_r;
  logic               phase_r;     // 1 while emitting the trailing pad block
  logic               out_valid_r;
  logic [BLOCK_W-1:0] out_block_r;
  logic               out_last_r;
  logic               load;
  logic [BLOCK_W-1:0] src;
  logic [BLOCK_W-1:0] ct;
  logic               hold;

  assign load = !out_valid_r || out_bus.ready;
  assign hold = head_job.pad_extra && !phase_r;
  assign pop  = load && head_valid && !hold;
  assign src  = phase_r ? PAD_BLOCK : head_job.block;
  assign ct   = frbc_round(src, key_r);

  assign out_bus.valid        = out_valid_r;
  assign out_bus.cipher_block = out_block_r;
  assign out_bus.last_block   = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        phase_r <= hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_block_r <= ct;
      out_last_r  <= phase_r ? 1'b1 : head_job.last;
    end
  end

endmodule

### rtl/feistel_round_block_cipher_top.sv
`timescale 1ns / 1ps
// ============================================================================
// feistel_round_block_cipher_top
// Byte-stream single-round Feistel block cipher with PKCS-style padding.
// ============================================================================
// Plaintext bytes enter on in_bus, one per transfer, and are packed MSB-first
// into 64-bit blocks; the byte flagged end_of_message closes the message and
// pads it with N bytes of value N (a whole pad block when the length is a
// multiple of eight). Each block goes through one DES-style round keyed by the
// 48-bit round key written on cfg_we/cfg_wdata, and leaves on out_bus with the
// right half in the top 32 bits and last_block set on the final block. The
// block takes one byte per cycle while in_bus.ready is high. The job for a
// block is written into the job queue when the byte completing it is
// transferred, and moves on into the output register once that register is
// free. A message that ends on a block boundary yields two results, its last
// data block and then a whole pad block. in_bus.ready drops only while the job
// queue is full: when the output side has been stalled, or when a block job
// follows straight after a message that ends on a block boundary.
// Write the key only while no message is in flight.
module feistel_round_block_cipher_top #(
  parameter int QUEUE_DEPTH = frbc_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [frbc_pkg::KEY_W-1:0] cfg_wdata,
  frbc_byte_if.sink                  in_bus,
  frbc_block_if.source               out_bus
);
  import frbc_pkg::*;

  // Front to queue
  logic      push;
  frbc_job_t push_job;
  logic      q_full;

  // Queue to back
  logic      pop;
  logic      head_valid;
  frbc_job_t head_job;

  // Packer and padder: classifies each completed block into a job
  frbc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decouples byte intake from result delivery
  frbc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Round logic and output register; expands a boundary finish into two transfers
  frbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_bus    (out_bus)
  );

endmodule
